/* hw/rtl/gsw_pkg.sv */
// ----------------------------------------------------------------------------
// gsw_pkg - shared types and constants of the 3x3 window filter
// Sample and window types, filter mode codes, the side-band record that
// travels down the pipeline, and the fixed limits of the Sobel path.
// ----------------------------------------------------------------------------
package gsw_pkg;

   localparam int unsigned SAMPLE_W  = 8;
   localparam int unsigned WIN_SIZE  = 9;
   localparam int unsigned GRAD_W    = 11;   // signed gradient, |g| <= 1020
   localparam int unsigned MAG_W     = 10;   // gradient magnitude
   localparam int unsigned SQ_W      = 20;   // one squared gradient
   localparam int unsigned SUMSQ_W   = 21;   // gx^2 + gy^2 <= 2080800
   localparam int unsigned RAD_W     = 16;   // radicand once saturation is split off
   localparam int unsigned ROOT_W    = 8;
   localparam int unsigned REM_W     = 10;
   localparam int unsigned GSUM_W    = 12;   // Gaussian weighted sum <= 4080

   // Window index of each sample, row-major.
   localparam int unsigned W_TL = 0;
   localparam int unsigned W_TM = 1;
   localparam int unsigned W_TR = 2;
   localparam int unsigned W_ML = 3;
   localparam int unsigned W_C  = 4;
   localparam int unsigned W_MR = 5;
   localparam int unsigned W_BL = 6;
   localparam int unsigned W_BM = 7;
   localparam int unsigned W_BR = 8;

   // Rounded magnitude reaches 256 exactly when gx^2 + gy^2 > 255*255 + 255.
   localparam logic [SUMSQ_W-1:0]  SOBEL_SAT_LIMIT = 21'd65280;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX      = 8'hFF;

   typedef logic [SAMPLE_W-1:0]               sample_type;
   typedef sample_type [WIN_SIZE-1:0]         window_type;

   typedef enum logic {
      MODE_GAUSS = 1'b0,
      MODE_SOBEL = 1'b1
   } filter_mode_type;

   // Per-item control carried alongside the Sobel arithmetic.
   typedef struct packed {
      filter_mode_type mode;
      logic            border;
      sample_type      center;
      sample_type      gauss;
      logic            sat;
   } side_type;

endpackage

/* hw/rtl/gsw_front.sv */
// ----------------------------------------------------------------------------
// gsw_front - window arithmetic front end
// Three register stages: weighted sums and gradients, then squares and the
// Gaussian rounding, then the sum of squares split into radicand and
// saturation flag.
// ----------------------------------------------------------------------------
module gsw_front
   import gsw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  window_type          window,
   input  logic                on_border,
   input  filter_mode_type     mode,
   output logic                out_valid,
   output logic [RAD_W-1:0]    radicand,
   output side_type            side
);

   // stage 1 next values
   logic [GSUM_W-1:0]        s1_gsum_in;
   logic [MAG_W-1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [GRAD_W-1:0] s1_gx_in, s1_gy_in;
   side_type                 s1_side_in;

   logic                     s1_valid_ff;
   logic [GSUM_W-1:0]        s1_gsum_ff;
   logic signed [GRAD_W-1:0] s1_gx_ff, s1_gy_ff;
   side_type                 s1_side_ff;

   // stage 2
   logic [MAG_W-1:0]         ax, ay;
   logic [SQ_W-1:0]          s2_sqx_in, s2_sqy_in;
   logic [SAMPLE_W-1:0]      gq;
   logic [3:0]               gr;
   logic                     ground;
   logic [SAMPLE_W:0]        gq_rnd;
   side_type                 s2_side_in;

   logic                     s2_valid_ff;
   logic [SQ_W-1:0]          s2_sqx_ff, s2_sqy_ff;
   side_type                 s2_side_ff;

   // stage 3
   logic [SUMSQ_W-1:0]       sumsq;
   side_type                 s3_side_in;

   logic                     s3_valid_ff;
   logic [RAD_W-1:0]         s3_rad_ff;
   side_type                 s3_side_ff;

   always_comb begin
      s1_gsum_in = GSUM_W'(window[W_TL]) + (GSUM_W'(window[W_TM]) << 1)
                 + GSUM_W'(window[W_TR]) + (GSUM_W'(window[W_ML]) << 1)
                 + (GSUM_W'(window[W_C]) << 2) + (GSUM_W'(window[W_MR]) << 1)
                 + GSUM_W'(window[W_BL]) + (GSUM_W'(window[W_BM]) << 1)
                 + GSUM_W'(window[W_BR]);
      gx_pos = MAG_W'(window[W_TR]) + (MAG_W'(window[W_MR]) << 1) + MAG_W'(window[W_BR]);
      gx_neg = MAG_W'(window[W_TL]) + (MAG_W'(window[W_ML]) << 1) + MAG_W'(window[W_BL]);
      gy_pos = MAG_W'(window[W_TL]) + (MAG_W'(window[W_TM]) << 1) + MAG_W'(window[W_TR]);
      gy_neg = MAG_W'(window[W_BL]) + (MAG_W'(window[W_BM]) << 1) + MAG_W'(window[W_BR]);
      s1_gx_in = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      s1_gy_in = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
      s1_side_in        = '0;
      s1_side_in.mode   = mode;
      s1_side_in.border = on_border;
      s1_side_in.center = window[W_C];
   end

   always_comb begin
      ax = s1_gx_ff[GRAD_W-1] ? MAG_W'(-s1_gx_ff) : s1_gx_ff[MAG_W-1:0];
      ay = s1_gy_ff[GRAD_W-1] ? MAG_W'(-s1_gy_ff) : s1_gy_ff[MAG_W-1:0];
      s2_sqx_in = SQ_W'(ax) * SQ_W'(ax);
      s2_sqy_in = SQ_W'(ay) * SQ_W'(ay);
      // divide by 16, round to nearest, ties to even
      gq     = s1_gsum_ff[GSUM_W-1:4];
      gr     = s1_gsum_ff[3:0];
      ground = (gr > 4'd8) || ((gr == 4'd8) && gq[0]);
      gq_rnd = {1'b0, gq} + {{SAMPLE_W{1'b0}}, ground};
      s2_side_in       = s1_side_ff;
      s2_side_in.gauss = gq_rnd[SAMPLE_W] ? SAMPLE_MAX : gq_rnd[SAMPLE_W-1:0];
   end

   always_comb begin
      sumsq = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
      s3_side_in     = s2_side_ff;
      s3_side_in.sat = sumsq > SOBEL_SAT_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_gsum_ff <= s1_gsum_in;
      s1_gx_ff   <= s1_gx_in;
      s1_gy_ff   <= s1_gy_in;
      s1_side_ff <= s1_side_in;
      s2_sqx_ff  <= s2_sqx_in;
      s2_sqy_ff  <= s2_sqy_in;
      s2_side_ff <= s2_side_in;
      s3_rad_ff  <= sumsq[RAD_W-1:0];
      s3_side_ff <= s3_side_in;
   end

   assign out_valid = s3_valid_ff;
   assign radicand  = s3_rad_ff;
   assign side      = s3_side_ff;

endmodule

/* hw/rtl/gsw_sqrt.sv */
// ----------------------------------------------------------------------------
// gsw_sqrt - pipelined integer square root
// Digit-by-digit root of a 16-bit radicand, two result bits per stage over
// four stages; gives the floor root and its remainder.
// ----------------------------------------------------------------------------
module gsw_sqrt
   import gsw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [RAD_W-1:0]    radicand,
   input  side_type            in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   root,
   output logic [REM_W-1:0]    remainder,
   output side_type            out_side
);

   localparam int unsigned STAGES = 4;

   logic                valid_ff [STAGES];
   logic [ROOT_W-1:0]   root_ff  [STAGES];
   logic [REM_W-1:0]    rem_ff   [STAGES];
   logic [RAD_W-1:0]    rad_ff   [STAGES];
   side_type            side_ff  [STAGES];

   logic [ROOT_W-1:0]   root_in  [STAGES];
   logic [REM_W-1:0]    rem_in   [STAGES];
   logic [RAD_W-1:0]    rad_in   [STAGES];

   // Two restoring steps: bring down a bit pair, try subtracting 4*root+1.
   function automatic logic [ROOT_W+REM_W-1:0] two_steps(input logic [ROOT_W-1:0] r0,
                                                         input logic [REM_W-1:0]  m0,
                                                         input logic [3:0]        bits);
      logic [ROOT_W-1:0] r;
      logic [REM_W-1:0]  m;
      logic [REM_W+1:0]  work;
      logic [REM_W+1:0]  trial;
      r = r0;
      m = m0;
      for (int j = 0; j < 2; j++) begin
         work  = {m, bits[3-2*j -: 2]};
         trial = {2'b00, r, 2'b01};
         if (work >= trial) begin
            m = REM_W'(work - trial);
            r = {r[ROOT_W-2:0], 1'b1};
         end else begin
            m = work[REM_W-1:0];
            r = {r[ROOT_W-2:0], 1'b0};
         end
      end
      return {r, m};
   endfunction

   always_comb begin
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            {root_in[s], rem_in[s]} = two_steps('0, '0, radicand[RAD_W-1 -: 4]);
            rad_in[s] = radicand << 4;
         end else begin
            {root_in[s], rem_in[s]} = two_steps(root_ff[s-1], rem_ff[s-1],
                                                rad_ff[s-1][RAD_W-1 -: 4]);
            rad_in[s] = rad_ff[s-1] << 4;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         root_ff[s] <= root_in[s];
         rem_ff[s]  <= rem_in[s];
         rad_ff[s]  <= rad_in[s];
      end
      side_ff[0] <= in_side;
      for (int s = 1; s < STAGES; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign root      = root_ff[STAGES-1];
   assign remainder = rem_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

/* hw/rtl/gauss_sobel_window_filter_unit.sv */
// ----------------------------------------------------------------------------
// gauss_sobel_window_filter_unit - 3x3 Gaussian blur / Sobel magnitude filter
// Takes one 3x3 window of 8-bit samples per clock and returns one filtered
// sample for each.
// ----------------------------------------------------------------------------
// Usage: drive a window on the req_ ports and pulse start; busy is never
// raised, so a new window may be transferred on every clock. Each window
// yields exactly one result, shown on rsp_out_sample for one cycle with
// rsp_strobe high, in order. The receiver cannot stall the block and must
// take every strobed result. The eight pipeline registers are: window
// sums and gradients, squaring, sum of squares, four stages of the square
// root (two root bits each) and the output register. csr_wr_en writes the
// filter mode (0 Gaussian blur, 1 Sobel magnitude); change it only when
// no window is in flight. Border pixels return their center sample.
// ----------------------------------------------------------------------------
module gauss_sobel_window_filter_unit
   import gsw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // command channel
   input  logic                start,
   output logic                busy,
   input  logic [SAMPLE_W-1:0] req_top_left,
   input  logic [SAMPLE_W-1:0] req_top_mid,
   input  logic [SAMPLE_W-1:0] req_top_right,
   input  logic [SAMPLE_W-1:0] req_mid_left,
   input  logic [SAMPLE_W-1:0] req_center,
   input  logic [SAMPLE_W-1:0] req_mid_right,
   input  logic [SAMPLE_W-1:0] req_bot_left,
   input  logic [SAMPLE_W-1:0] req_bot_mid,
   input  logic [SAMPLE_W-1:0] req_bot_right,
   input  logic                req_on_border,
   // result channel
   output logic                rsp_strobe,
   output logic [SAMPLE_W-1:0] rsp_out_sample,
   // configuration
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);

   localparam int unsigned LATENCY = 8;

   filter_mode_type     mode_ff;
   window_type          window;
   logic                take;

   logic                front_valid;
   logic [RAD_W-1:0]    front_rad;
   side_type            front_side;

   logic                sq_valid;
   logic [ROOT_W-1:0]   sq_root;
   logic [REM_W-1:0]    sq_rem;
   side_type            sq_side;

   logic                round_up;
   logic [ROOT_W:0]     sobel_rnd;
   logic [SAMPLE_W-1:0] sobel_val;
   logic [SAMPLE_W-1:0] sample_in;

   logic                out_valid_ff;
   logic [SAMPLE_W-1:0] out_sample_ff;

   // The pipeline never stalls, so the block always takes a transfer.
   assign busy = 1'b0;
   assign take = start && !busy;

   // Mode register: bits above bit 0 do not exist on the port.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GAUSS;
      end else if (csr_wr_en) begin
         mode_ff <= filter_mode_type'(csr_wr_data);
      end
   end

   always_comb begin
      window[W_TL] = req_top_left;
      window[W_TM] = req_top_mid;
      window[W_TR] = req_top_right;
      window[W_ML] = req_mid_left;
      window[W_C]  = req_center;
      window[W_MR] = req_mid_right;
      window[W_BL] = req_bot_left;
      window[W_BM] = req_bot_mid;
      window[W_BR] = req_bot_right;
   end

   // Stages 1-3: sums, gradients, squares, Gaussian rounding, sum of squares and saturation flag.
   gsw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .window    (window),
      .on_border (req_on_border),
      .mode      (mode_ff),
      .out_valid (front_valid),
      .radicand  (front_rad),
      .side      (front_side)
   );

   // Stages 4-7: floor square root with remainder.
   gsw_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .radicand  (front_rad),
      .in_side   (front_side),
      .out_valid (sq_valid),
      .root      (sq_root),
      .remainder (sq_rem),
      .out_side  (sq_side)
   );

   // Stage 8: round the root to nearest and pick the result.
   // The root is never exactly halfway, so round up when n - k*k > k.
   always_comb begin
      round_up  = sq_rem > REM_W'(sq_root);
      sobel_rnd = {1'b0, sq_root} + {{ROOT_W{1'b0}}, round_up};
      if (sq_side.sat || sobel_rnd[ROOT_W]) begin
         sobel_val = SAMPLE_MAX;
      end else begin
         sobel_val = sobel_rnd[SAMPLE_W-1:0];
      end
      if (sq_side.border) begin
         sample_in = sq_side.center;
      end else begin
         case (sq_side.mode)
            MODE_SOBEL: sample_in = sobel_val;
            MODE_GAUSS: sample_in = sq_side.gauss;
            default:    sample_in = sq_side.gauss;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_sample_ff <= sample_in;
   end

   assign rsp_strobe     = out_valid_ff;
   assign rsp_out_sample = out_sample_ff;

   // Every transfer comes back as exactly one result.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      take |-> ##LATENCY rsp_strobe)
      else $error("transfer produced no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(take, LATENCY))
      else $error("result without a transfer");

   // Border pixels pass the center sample straight through.
   a_border_center: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_on_border, LATENCY))
         |-> (rsp_out_sample == $past(req_center, LATENCY)))
      else $error("border pixel did not return its center sample");

endmodule
